// ===== design/ccts_pkg.sv =====
package ccts_pkg;

    localparam int CCTS_SAMPLES    = 8;
    localparam int CCTS_COUNT_BITS = 16;

    localparam int CCTS_VAL_W  = 16;
    localparam int CCTS_ADDR_W = 4;
    localparam int CCTS_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_DISCHARGE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [CCTS_VAL_W-1:0] DISCHARGE_RESET = 16'd25000;
    localparam logic [CCTS_VAL_W-1:0] TIMEOUT_RESET   = 16'd50000;

    // 900*f + 100*m over 1000 reduces to (9*f + m) / 10; the sum stays below 2^20,
    // where x*838861 >> 23 is exact for x/10
    localparam int                FILT_SUM_W  = 20;
    localparam logic [19:0]       FILT_RECIP  = 20'd838861;
    localparam int                FILT_SHIFT  = 23;
    localparam int                FILT_PROD_W = FILT_SUM_W + 20;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_DISCHARGE = 3'b010,
        PH_CHARGE    = 3'b100
    } phase_t;

    typedef struct packed {
        logic                  drive;
        logic                  abort;
        logic                  done;
        logic                  good;
        logic [CCTS_VAL_W-1:0] sample;
    } step_t;

    typedef struct packed {
        logic                  drive_level;
        logic                  reading_valid;
        logic [CCTS_VAL_W-1:0] reading_max;
        logic [CCTS_VAL_W-1:0] filtered_value;
        logic                  fault;
    } result_t;

endpackage

// ===== design/capacitive_charge_time_sensor_unit.sv =====
// Capacitive charge-time sensor. Feed one request per microsecond tick carrying
// s_rising_edge; each request yields exactly one result with the pin drive level
// for that tick, the completion flag, maximum and fault of a reading of SAMPLES
// samples, and the smoothed value. A request passes an input register and then a
// result register on its way to the output, and one request can be taken every
// cycle unless m_ready holds a waiting result; the sequencer and filter state advance
// once per request in the cycle it moves into the result register. Program enable,
// discharge_ticks and timeout_ticks through the APB port at byte addresses 0, 4
// and 8 while no requests are in flight; clearing enable drops the partial
// reading but keeps the filter.
module capacitive_charge_time_sensor_unit
    import ccts_pkg::*;
#(
    parameter int SAMPLES    = CCTS_SAMPLES,
    parameter int COUNT_BITS = CCTS_COUNT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_rising_edge,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_drive_level,
    output logic                   m_reading_valid,
    output logic [CCTS_VAL_W-1:0]  m_reading_max,
    output logic [CCTS_VAL_W-1:0]  m_filtered_value,
    output logic                   m_fault,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CCTS_ADDR_W-1:0] paddr,
    input  logic [CCTS_DATA_W-1:0] pwdata,
    output logic [CCTS_DATA_W-1:0] prdata,
    output logic                   pready
);

    logic                  enable_reg;
    logic [CCTS_VAL_W-1:0] discharge_reg;
    logic [CCTS_VAL_W-1:0] timeout_reg;

    logic    in_valid_reg;
    logic    rise_reg;
    logic    out_valid_reg;
    result_t result_reg;
    logic    advance;
    step_t   step;
    result_t result;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            discharge_reg <= DISCHARGE_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_ENABLE:    enable_reg    <= pwdata[0];
                REG_DISCHARGE: discharge_reg <= pwdata[CCTS_VAL_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[CCTS_VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE:    prdata = CCTS_DATA_W'(enable_reg);
            REG_DISCHARGE: prdata = CCTS_DATA_W'(discharge_reg);
            REG_TIMEOUT:   prdata = CCTS_DATA_W'(timeout_reg);
            default:       prdata = '0;
        endcase
    end

    // advance the held request into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rise_reg <= s_rising_edge;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    ccts_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .rise            (rise_reg),
        .enable          (enable_reg),
        .discharge_ticks (discharge_reg),
        .timeout_ticks   (timeout_reg),
        .step            (step)
    );

    ccts_filter #(
        .SAMPLES(SAMPLES)
    ) u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .step    (step),
        .result  (result)
    );

    assign m_valid          = out_valid_reg;
    assign m_drive_level    = result_reg.drive_level;
    assign m_reading_valid  = result_reg.reading_valid;
    assign m_reading_max    = result_reg.reading_max;
    assign m_filtered_value = result_reg.filtered_value;
    assign m_fault          = result_reg.fault;

endmodule

// ===== design/ccts_step.sv =====
module ccts_step
    import ccts_pkg::*;
#(
    parameter int COUNT_BITS = CCTS_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  rise,
    input  logic                  enable,
    input  logic [CCTS_VAL_W-1:0] discharge_ticks,
    input  logic [CCTS_VAL_W-1:0] timeout_ticks,
    output step_t                 step
);

    localparam int CMP_W = (COUNT_BITS > CCTS_VAL_W) ? COUNT_BITS : CCTS_VAL_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      count_cmp, inc_cmp, dis_cmp, to_cmp;

    always_comb begin
        count_inc = (tick_count_reg != COUNT_MAX) ? tick_count_reg + 1'b1 : tick_count_reg;
        count_cmp = CMP_W'(tick_count_reg);
        inc_cmp   = CMP_W'(count_inc);
        dis_cmp   = CMP_W'(discharge_ticks);
        to_cmp    = CMP_W'(timeout_ticks);
    end

    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        step            = '0;
        if (!enable) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            step.abort      = 1'b1;
        end else begin
            case (phase_reg)
                PH_DISCHARGE: begin
                    if (inc_cmp >= dis_cmp || count_inc == COUNT_MAX) begin
                        phase_next      = PH_CHARGE;
                        tick_count_next = '0;
                    end else begin
                        tick_count_next = count_inc;
                    end
                end
                PH_CHARGE: begin
                    step.drive = 1'b1;
                    if (count_cmp >= to_cmp) begin
                        step.done = 1'b1;
                    end else if (rise) begin
                        step.done   = 1'b1;
                        step.sample = CCTS_VAL_W'(tick_count_reg);
                        step.good   = (tick_count_reg != '0);
                    end else if (inc_cmp >= to_cmp || count_inc == COUNT_MAX) begin
                        step.done = 1'b1;
                    end else begin
                        tick_count_next = count_inc;
                    end
                    if (step.done) begin
                        phase_next      = PH_DISCHARGE;
                        tick_count_next = '0;
                    end
                end
                default: begin
                    // idle or a stray code: start a discharge
                    phase_next      = PH_DISCHARGE;
                    tick_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

// ===== design/ccts_filter.sv =====
module ccts_filter
    import ccts_pkg::*;
#(
    parameter int SAMPLES = CCTS_SAMPLES
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  step_t   step,
    output result_t result
);

    localparam int IDX_W = $clog2(SAMPLES + 1);

    logic [IDX_W-1:0]      sample_index_reg, sample_index_next;
    logic [CCTS_VAL_W-1:0] running_max_reg, running_max_next;
    logic                  any_valid_reg, any_valid_next;
    logic [CCTS_VAL_W-1:0] smoothed_reg, smoothed_next;
    logic                  filter_loaded_reg, filter_loaded_next;

    logic [IDX_W-1:0]       index_inc;
    logic [CCTS_VAL_W-1:0]  new_max;
    logic                   new_any;
    logic [FILT_SUM_W-1:0]  filt_sum;
    logic [FILT_PROD_W-1:0] filt_prod;
    logic [CCTS_VAL_W-1:0]  filt_quot;

    always_comb begin
        index_inc = sample_index_reg + 1'b1;
        new_max   = (step.good && step.sample > running_max_reg) ? step.sample
                                                                 : running_max_reg;
        new_any   = any_valid_reg | step.good;
        filt_sum  = (FILT_SUM_W'(smoothed_reg) << 3) + FILT_SUM_W'(smoothed_reg)
                  + FILT_SUM_W'(new_max);
        filt_prod = FILT_PROD_W'(filt_sum) * FILT_PROD_W'(FILT_RECIP);
        filt_quot = filt_prod[FILT_SHIFT +: CCTS_VAL_W];
    end

    always_comb begin
        sample_index_next  = sample_index_reg;
        running_max_next   = running_max_reg;
        any_valid_next     = any_valid_reg;
        smoothed_next      = smoothed_reg;
        filter_loaded_next = filter_loaded_reg;
        result             = '0;
        result.drive_level = step.drive;
        if (step.abort) begin
            sample_index_next = '0;
            running_max_next  = '0;
            any_valid_next    = 1'b0;
        end else if (step.done) begin
            if (index_inc == IDX_W'(SAMPLES)) begin
                result.reading_valid = 1'b1;
                result.reading_max   = new_any ? new_max : '0;
                result.fault         = !new_any;
                if (new_any) begin
                    smoothed_next      = filter_loaded_reg ? filt_quot : new_max;
                    filter_loaded_next = 1'b1;
                end
                sample_index_next = '0;
                running_max_next  = '0;
                any_valid_next    = 1'b0;
            end else begin
                sample_index_next = index_inc;
                running_max_next  = new_max;
                any_valid_next    = new_any;
            end
        end
        result.filtered_value = smoothed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg  <= '0;
            running_max_reg   <= '0;
            any_valid_reg     <= 1'b0;
            smoothed_reg      <= '0;
            filter_loaded_reg <= 1'b0;
        end else if (advance) begin
            sample_index_reg  <= sample_index_next;
            running_max_reg   <= running_max_next;
            any_valid_reg     <= any_valid_next;
            smoothed_reg      <= smoothed_next;
            filter_loaded_reg <= filter_loaded_next;
        end
    end

endmodule
